### sv/mi3_pkg.sv
package mi3_pkg;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned DivSteps = 33;
  localparam int unsigned EpsW     = 17;
  localparam logic [EpsW-1:0] EpsReset = 17'd7;

  typedef struct packed {
    logic signed [31:0] in_r1c1;
    logic signed [31:0] in_r1c2;
    logic signed [31:0] in_r1c3;
    logic signed [31:0] in_r2c1;
    logic signed [31:0] in_r2c2;
    logic signed [31:0] in_r2c3;
    logic signed [31:0] in_r3c1;
    logic signed [31:0] in_r3c2;
    logic signed [31:0] in_r3c3;
  } mi3_in_t;

  typedef struct packed {
    logic signed [31:0] out_r1c1;
    logic signed [31:0] out_r1c2;
    logic signed [31:0] out_r1c3;
    logic signed [31:0] out_r2c1;
    logic signed [31:0] out_r2c2;
    logic signed [31:0] out_r2c3;
    logic signed [31:0] out_r3c1;
    logic signed [31:0] out_r3c2;
    logic signed [31:0] out_r3c3;
    logic               singular;
  } mi3_out_t;

  typedef struct packed {
    logic             sing;
    logic [8:0]       neg;
    logic [96:0]      adet;
    logic [8:0][63:0] mag;
    mi3_in_t          mat;
  } mi3_job_t;

  typedef struct packed {
    mi3_job_t         job;
    logic [8:0][95:0] rem;
    logic [8:0][31:0] quo;
    logic [8:0]       ovf;
  } mi3_div_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mi3_qstat_t;

endpackage

### sv/mi3_front.sv
module mi3_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mi3_pkg::mi3_in_t       in_data_i,
  input  logic [16:0]            eps_i,
  input  mi3_pkg::mi3_qstat_t    qstat_i,
  output logic                   job_valid_o,
  output mi3_pkg::mi3_job_t      job_o
);
  import mi3_pkg::*;

  logic adv;
  logic signed [31:0] m [3][3];
  logic signed [31:0] mb [3];

  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q;
  mi3_in_t a_mat_q, b_mat_q, c_mat_q, d_mat_q;
  logic signed [63:0] a_p_d [3][3], a_p_q [3][3];
  logic signed [63:0] a_n_d [3][3], a_n_q [3][3];
  logic signed [64:0] b_cof_d [3][3], b_cof_q [3][3], c_cof_q [3][3];
  logic signed [64:0] c_pl_d [3], c_pl_q [3], c_ph_d [3], c_ph_q [3];
  logic signed [96:0] d_det_d, d_det_q;
  logic [8:0][63:0] d_mag_d, d_mag_q;
  logic [8:0] d_cneg_d, d_cneg_q;
  mi3_job_t e_job_d, e_job_q;

  assign adv        = !(e_valid_q && qstat_i.full);
  assign in_stall_o = !adv;

  assign m[0][0] = in_data_i.in_r1c1;
  assign m[0][1] = in_data_i.in_r1c2;
  assign m[0][2] = in_data_i.in_r1c3;
  assign m[1][0] = in_data_i.in_r2c1;
  assign m[1][1] = in_data_i.in_r2c2;
  assign m[1][2] = in_data_i.in_r2c3;
  assign m[2][0] = in_data_i.in_r3c1;
  assign m[2][1] = in_data_i.in_r3c2;
  assign m[2][2] = in_data_i.in_r3c3;

  assign mb[0] = b_mat_q.in_r1c1;
  assign mb[1] = b_mat_q.in_r1c2;
  assign mb[2] = b_mat_q.in_r1c3;

  for (genvar gr = 0; gr < 3; gr++) begin : g_row
    for (genvar gc = 0; gc < 3; gc++) begin : g_col
      localparam int R1 = (gr + 1) % 3;
      localparam int R2 = (gr + 2) % 3;
      localparam int C1 = (gc + 1) % 3;
      localparam int C2 = (gc + 2) % 3;
      localparam int Idx = gr * 3 + gc;
      assign a_p_d[gr][gc] = m[R1][C1] * m[R2][C2];
      assign a_n_d[gr][gc] = m[R1][C2] * m[R2][C1];
      assign b_cof_d[gr][gc] = $signed({a_p_q[gr][gc][63], a_p_q[gr][gc]})
                             - $signed({a_n_q[gr][gc][63], a_n_q[gr][gc]});
      // adjugate is the cofactor transpose
      assign d_cneg_d[Idx] = c_cof_q[gc][gr][64];
      always_comb begin
        logic signed [64:0] neg_cof;
        neg_cof = -c_cof_q[gc][gr];
        d_mag_d[Idx] = c_cof_q[gc][gr][64] ? neg_cof[63:0] : c_cof_q[gc][gr][63:0];
      end
    end
  end

  for (genvar gc = 0; gc < 3; gc++) begin : g_det
    assign c_pl_d[gc] = $signed({33'b0, b_cof_q[0][gc][31:0]})
                      * $signed({{33{mb[gc][31]}}, mb[gc]});
    assign c_ph_d[gc] = $signed({{32{b_cof_q[0][gc][64]}}, b_cof_q[0][gc][64:32]})
                      * $signed({{33{mb[gc][31]}}, mb[gc]});
  end

  always_comb begin
    d_det_d = '0;
    for (int i = 0; i < 3; i++) begin
      d_det_d = d_det_d + $signed({c_ph_q[i], 32'b0})
                        + $signed({{32{c_pl_q[i][64]}}, c_pl_q[i]});
    end
  end

  always_comb begin
    logic signed [96:0] neg_det;
    neg_det        = -d_det_q;
    e_job_d.adet   = d_det_q[96] ? neg_det : d_det_q;
    e_job_d.sing   = e_job_d.adet <= {48'b0, eps_i, 32'b0};
    e_job_d.neg    = d_cneg_q ^ {9{d_det_q[96]}};
    e_job_d.mag    = d_mag_q;
    e_job_d.mat    = d_mat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_mat_q  <= in_data_i;
      a_p_q    <= a_p_d;
      a_n_q    <= a_n_d;
      b_mat_q  <= a_mat_q;
      b_cof_q  <= b_cof_d;
      c_mat_q  <= b_mat_q;
      c_cof_q  <= b_cof_q;
      c_pl_q   <= c_pl_d;
      c_ph_q   <= c_ph_d;
      d_mat_q  <= c_mat_q;
      d_det_q  <= d_det_d;
      d_mag_q  <= d_mag_d;
      d_cneg_q <= d_cneg_d;
      e_job_q  <= e_job_d;
    end
  end

  assign job_valid_o = e_valid_q;
  assign job_o       = e_job_q;

endmodule

### sv/mi3_queue.sv
module mi3_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  mi3_pkg::mi3_job_t   push_job_i,
  input  logic                pop_i,
  output mi3_pkg::mi3_qstat_t stat_o,
  output mi3_pkg::mi3_job_t   head_o
);
  import mi3_pkg::*;

  mi3_job_t mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign stat_o.full  = cnt_q == QCntW'(QDepth);
  assign stat_o.empty = cnt_q == '0;
  assign push = push_valid_i && !stat_o.full;
  assign pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

endmodule

### sv/mi3_back.sv
module mi3_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mi3_pkg::mi3_qstat_t qstat_i,
  input  mi3_pkg::mi3_job_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mi3_pkg::mi3_out_t   out_data_o
);
  import mi3_pkg::*;

  logic adv;
  logic v_q [DivSteps+1];
  mi3_div_t st_d [DivSteps+1];
  mi3_div_t st_q [DivSteps+1];
  logic out_valid_q;
  mi3_out_t out_d, out_q;

  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = adv && !qstat_i.empty;

  always_comb begin
    st_d[0].job = head_i;
    st_d[0].quo = '0;
    st_d[0].ovf = '0;
    for (int i = 0; i < 9; i++) begin
      st_d[0].rem[i] = {head_i.mag[i], 32'b0};
    end
  end

  // first step only flags a quotient of 2^32 or more, then one quotient bit a step
  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    localparam int Sh = DivSteps - k;
    always_comb begin
      logic [128:0] sub;
      logic ge;
      st_d[k] = st_q[k-1];
      sub = {32'b0, st_q[k-1].job.adet} << Sh;
      for (int i = 0; i < 9; i++) begin
        ge = {33'b0, st_q[k-1].rem[i]} >= sub;
        if (k == 1) begin
          st_d[k].ovf[i] = ge;
        end else if (ge) begin
          st_d[k].rem[i] = st_q[k-1].rem[i] - sub[95:0];
          st_d[k].quo[i][Sh[4:0]] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [8:0][31:0] res;
    logic [31:0] q;
    logic big;
    for (int i = 0; i < 9; i++) begin
      q   = st_q[DivSteps].quo[i];
      big = st_q[DivSteps].ovf[i] || q[31];
      if (st_q[DivSteps].job.neg[i]) begin
        res[8-i] = big ? 32'h8000_0000 : -q;
      end else begin
        res[8-i] = big ? 32'h7FFF_FFFF : q;
      end
    end
    if (st_q[DivSteps].job.sing) begin
      out_d = mi3_out_t'({st_q[DivSteps].job.mat, 1'b1});
    end else begin
      out_d = mi3_out_t'({res, 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivSteps; k++) begin
        v_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= !qstat_i.empty;
      for (int k = 1; k <= DivSteps; k++) begin
        v_q[k] <= v_q[k-1];
      end
      out_valid_q <= v_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= DivSteps; k++) begin
        st_q[k] <= st_d[k];
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/matrix_inverse_3x3.sv
// Throughput: one matrix per cycle while neither in_stall_o nor out_stall_i holds
// the flow; five front stages form the determinant, a four-entry queue, then a
// 33-step pipelined restoring divider per element.
// Reset: clears all valid bits and the queue, and sets the epsilon to 7.
module matrix_inverse_3x3 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [16:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mi3_pkg::mi3_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mi3_pkg::mi3_out_t out_data_o
);
  import mi3_pkg::*;

  logic [EpsW-1:0] eps_q;
  logic f_valid;
  mi3_job_t f_job, q_head;
  mi3_qstat_t q_stat;
  logic q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      eps_q <= cfg_data_i;
    end
  end

  mi3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .eps_i       (eps_q),
    .qstat_i     (q_stat),
    .job_valid_o (f_valid),
    .job_o       (f_job)
  );

  mi3_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_job_i   (f_job),
    .pop_i        (q_pop),
    .stat_o       (q_stat),
    .head_o       (q_head)
  );

  mi3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (q_stat),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_stat.full)
    else $error("input stalled while queue has room");

  a_no_invented_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty && !f_valid |=> q_stat.empty)
    else $error("queue filled without a front beat");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !q_stat.empty)
    else $error("queue status inconsistent");

endmodule

### verif/testbench.sv
module testbench;
  import mi3_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 60;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [EpsW-1:0]   cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  mi3_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  mi3_out_t          out_data_o;

  mi3_in_t         matrix_queue[$];
  mi3_out_t        inverse_queue[$];
  logic [EpsW-1:0] epsilon_q;
  int unsigned     cycle_count;
  int unsigned     error_count;
  int unsigned     burst_left;
  int unsigned     gap_left;
  int unsigned     hold_left;
  logic            hold_req;
  int unsigned     stall_mode;

  matrix_inverse_3x3 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic signed [31:0] elem(mi3_in_t m, int idx);
    logic [287:0] flat;
    flat = m;
    return flat[287 - 32*idx -: 32];
  endfunction

  function automatic mi3_out_t invert_matrix(mi3_in_t m, logic [EpsW-1:0] eps);
    logic signed [31:0]  a [3][3];
    logic signed [65:0]  cof [3][3];
    logic signed [98:0]  det;
    logic [98:0]         adet;
    logic [98:0]         thr;
    logic [65:0]         mag;
    logic [130:0]        num;
    logic [130:0]        quo;
    logic [31:0]         code;
    logic [287:0]        res;
    logic                neg;
    mi3_out_t            o;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) a[r][c] = elem(m, r*3 + c);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = 66'(a[(r+1)%3][(c+1)%3]) * 66'(a[(r+2)%3][(c+2)%3])
                  - 66'(a[(r+1)%3][(c+2)%3]) * 66'(a[(r+2)%3][(c+1)%3]);
    det = 0;
    for (int c = 0; c < 3; c++) det = det + 99'(cof[0][c]) * 99'(a[0][c]);
    adet = det[98] ? -det : det;
    thr = 99'(eps) << 32;
    if (adet <= thr) begin
      o = '0;
      o[288:1] = m;
      o.singular = 1'b1;
      return o;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        neg = cof[c][r][65] != det[98];
        mag = cof[c][r][65] ? -cof[c][r] : cof[c][r];
        num = 131'(mag) << 32;
        quo = num / 131'(adet);
        if (neg) code = (quo >= 131'h80000000) ? 32'h80000000 : -quo[31:0];
        else code = (quo > 131'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
        res[287 - 32*(r*3+c) -: 32] = code;
      end
    o.out_r1c1 = res[287:256]; o.out_r1c2 = res[255:224]; o.out_r1c3 = res[223:192];
    o.out_r2c1 = res[191:160]; o.out_r2c2 = res[159:128]; o.out_r2c3 = res[127:96];
    o.out_r3c1 = res[95:64];   o.out_r3c2 = res[63:32];   o.out_r3c3 = res[31:0];
    o.singular = 1'b0;
    return o;
  endfunction

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
      3: return $urandom;
      4, 5: return 32'(signed'($urandom_range(0, 262143)) - 131072);
      default: return 32'(signed'($urandom_range(0, 16777215)) - 8388608);
    endcase
  endfunction

  function automatic mi3_in_t rand_matrix();
    mi3_in_t m;
    logic [287:0] flat;
    for (int i = 0; i < 9; i++) flat[287 - 32*i -: 32] = rand_elem();
    m = flat;
    // make some rows dependent so singular cases show up
    if ($urandom_range(7) == 0) begin
      m.in_r3c1 = m.in_r1c1 + m.in_r2c1;
      m.in_r3c2 = m.in_r1c2 + m.in_r2c2;
      m.in_r3c3 = m.in_r1c3 + m.in_r2c3;
    end
    return m;
  endfunction

  function automatic mi3_in_t diag_matrix(logic signed [31:0] d);
    mi3_in_t m;
    m = '0;
    m.in_r1c1 = d; m.in_r2c2 = d; m.in_r3c3 = d;
    return m;
  endfunction

  // driver: bursts and gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) inverse_queue.push_back(invert_matrix(in_data_i, epsilon_q));
      if (gap_left != 0 || matrix_queue.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= matrix_queue.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 5);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left   <= 150;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= hold_left != 1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(3) == 0);
        default: out_stall_i <= ($urandom_range(1) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mi3_out_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_queue.size() == 0) begin
        $error("unexpected beat %h", out_data_o);
        error_count++;
      end else begin
        exp_v = inverse_queue.pop_front();
        if (out_data_o.out_r1c1 !== exp_v.out_r1c1) begin
          $error("out_r1c1 exp %h got %h", exp_v.out_r1c1, out_data_o.out_r1c1); error_count++; end
        if (out_data_o.out_r1c2 !== exp_v.out_r1c2) begin
          $error("out_r1c2 exp %h got %h", exp_v.out_r1c2, out_data_o.out_r1c2); error_count++; end
        if (out_data_o.out_r1c3 !== exp_v.out_r1c3) begin
          $error("out_r1c3 exp %h got %h", exp_v.out_r1c3, out_data_o.out_r1c3); error_count++; end
        if (out_data_o.out_r2c1 !== exp_v.out_r2c1) begin
          $error("out_r2c1 exp %h got %h", exp_v.out_r2c1, out_data_o.out_r2c1); error_count++; end
        if (out_data_o.out_r2c2 !== exp_v.out_r2c2) begin
          $error("out_r2c2 exp %h got %h", exp_v.out_r2c2, out_data_o.out_r2c2); error_count++; end
        if (out_data_o.out_r2c3 !== exp_v.out_r2c3) begin
          $error("out_r2c3 exp %h got %h", exp_v.out_r2c3, out_data_o.out_r2c3); error_count++; end
        if (out_data_o.out_r3c1 !== exp_v.out_r3c1) begin
          $error("out_r3c1 exp %h got %h", exp_v.out_r3c1, out_data_o.out_r3c1); error_count++; end
        if (out_data_o.out_r3c2 !== exp_v.out_r3c2) begin
          $error("out_r3c2 exp %h got %h", exp_v.out_r3c2, out_data_o.out_r3c2); error_count++; end
        if (out_data_o.out_r3c3 !== exp_v.out_r3c3) begin
          $error("out_r3c3 exp %h got %h", exp_v.out_r3c3, out_data_o.out_r3c3); error_count++; end
        if (out_data_o.singular !== exp_v.singular) begin
          $error("singular exp %b got %b", exp_v.singular, out_data_o.singular); error_count++; end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("matrix_inverse_3x3: mismatch");
      $finish;
    end
  end

  task automatic drain();
    while (matrix_queue.size() != 0 || in_valid_i || inverse_queue.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_epsilon(logic [EpsW-1:0] v);
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    epsilon_q   = v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    mi3_in_t m;
    logic [EpsW-1:0] eps_set [5];
    cycle_count = 0;
    error_count = 0;
    hold_req    = 1'b0;
    stall_mode  = 0;
    epsilon_q   = EpsReset;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    matrix_queue.push_back(diag_matrix(32'sh00010000));
    matrix_queue.push_back(diag_matrix(32'sh00020000));
    matrix_queue.push_back(diag_matrix(32'shFFFF0000));
    matrix_queue.push_back(diag_matrix(32'sh00000001));
    matrix_queue.push_back(diag_matrix(32'sh00000100));
    matrix_queue.push_back(diag_matrix(32'sh7FFFFFFF));
    matrix_queue.push_back(diag_matrix(32'sh80000000));
    matrix_queue.push_back('0);
    m = '1;
    matrix_queue.push_back(m);
    m = {9{32'sh80000000}};
    matrix_queue.push_back(m);
    m = {9{32'sh7FFFFFFF}};
    matrix_queue.push_back(m);
    m = diag_matrix(32'sh80000000);
    m.in_r1c3 = 32'sh7FFFFFFF; m.in_r3c1 = 32'sh7FFFFFFF;
    matrix_queue.push_back(m);
    m = diag_matrix(32'sh00010000);
    m.in_r1c2 = 32'sh00030000; m.in_r2c1 = 32'shFFFE0000; m.in_r3c2 = 32'sh00000005;
    matrix_queue.push_back(m);
    m = {32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h0};
    matrix_queue.push_back(m);
    drain();

    eps_set[0] = 17'd0;
    eps_set[1] = 17'd65536;
    eps_set[2] = 17'h1FFFF;
    eps_set[3] = 17'd1;
    eps_set[4] = EpsReset;
    for (int p = 0; p < 5; p++) begin
      write_epsilon(p == 4 ? 17'($urandom_range(0, 65536)) : eps_set[p]);
      stall_mode = p % 3;
      matrix_queue.push_back(diag_matrix(32'sh00000100));
      matrix_queue.push_back(diag_matrix(32'sh00000001));
      for (int i = 0; i < 365; i++) matrix_queue.push_back(rand_matrix());
      if (p == 1) begin
        hold_req = 1'b1;
        wait (hold_left != 0);
        hold_req = 1'b0;
      end
      drain();
    end

    if (error_count == 0) $display("matrix_inverse_3x3: match");
    else $display("matrix_inverse_3x3: mismatch");
    $finish;
  end

endmodule
